>>> rtl/sdt_pkg.sv
`default_nettype none

package sdt_pkg;

    localparam int WIDE_W = 64;
    localparam int B_W    = 33;
    localparam int PROD_W = WIDE_W + B_W;
    localparam int DEN_W  = 46;
    localparam int QUO_W  = 33;
    localparam int DIVIDEND_EXP = 48;

    typedef logic signed [WIDE_W-1:0] t_wide;

endpackage

`default_nettype wire

>>> rtl/sdt_mul.sv
`default_nettype none

module sdt_mul import sdt_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  t_wide             i_a,
    input  logic [B_W-1:0]    i_b,
    output logic              o_done,
    output logic [PROD_W-1:0] o_prod
);

    localparam int HALF = WIDE_W / 2;

    typedef enum logic [1:0] {PH_IDLE, PH_LO, PH_HI} t_phase;

    t_phase                 r_phase;
    logic [WIDE_W-1:0]      r_mag;
    logic [B_W-1:0]         r_b;
    logic [HALF+B_W-1:0]    r_lo;
    logic [PROD_W-1:0]      r_prod;
    logic                   r_done;

    logic [HALF-1:0]        part_a;
    logic [HALF+B_W-1:0]    part_p;

    // One 32 x 33 multiplier serves both halves of the magnitude.
    assign part_a = (r_phase == PH_HI) ? r_mag[WIDE_W-1:HALF] : r_mag[HALF-1:0];
    assign part_p = {{B_W{1'b0}}, part_a} * {{HALF{1'b0}}, r_b};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= (r_phase == PH_HI);
            unique case (r_phase)
                PH_IDLE: begin
                    if (i_start) begin
                        r_mag   <= i_a[WIDE_W-1] ? -i_a : i_a;
                        r_b     <= i_b;
                        r_phase <= PH_LO;
                    end
                end
                PH_LO: begin
                    r_lo    <= part_p;
                    r_phase <= PH_HI;
                end
                PH_HI: begin
                    r_prod  <= {part_p, {HALF{1'b0}}} + PROD_W'(r_lo);
                    r_phase <= PH_IDLE;
                end
                default: begin
                    r_phase <= PH_IDLE;
                end
            endcase
        end
    end

    assign o_done = r_done;
    assign o_prod = r_prod;

endmodule

`default_nettype wire

>>> rtl/sdt_div.sv
`default_nettype none

module sdt_div import sdt_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_done,
    output logic [QUO_W-1:0] o_quo
);

    localparam int CNT_W = $clog2(QUO_W);
    localparam logic [DEN_W-1:0] REM_INIT = DEN_W'(1) << (DIVIDEND_EXP - QUO_W);

    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic [QUO_W-1:0] r_quo;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [DEN_W:0]   rem_sh;
    logic [DEN_W:0]   rem_diff;
    logic             rem_ge;

    // Restoring division of 2^48 by the denominator, one quotient bit a cycle.
    assign rem_sh   = {r_rem, 1'b0};
    assign rem_ge   = rem_sh >= {1'b0, r_den};
    assign rem_diff = rem_sh - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else if (i_start) begin
            r_rem  <= REM_INIT;
            r_den  <= i_den;
            r_quo  <= '0;
            r_cnt  <= CNT_W'(QUO_W - 1);
            r_busy <= 1'b1;
            r_done <= 1'b0;
        end else if (r_busy) begin
            r_rem <= rem_ge ? rem_diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
            r_quo <= {r_quo[QUO_W-2:0], rem_ge};
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end else begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

`default_nettype wire

>>> rtl/smooth_damp_tracker.sv
// Channel   | Direction | Signals                              | Payload
// ----------+-----------+--------------------------------------+-------------------------------
// s         | in        | i_s_tvalid, o_s_tready, i_s_tdata    | positions and step time
// m         | out       | o_m_tvalid, i_m_tready, o_m_tdata,   | smoothed position, overshoot
//           |           | o_m_tuser                            |
// cfg       | in        | i_cfg_valid, o_cfg_ready, i_cfg_data | smoothing time
//
// An item issues up to 17 multiplies on the shared unit; the overshoot rule ends an item early,
// and a zero smoothing time skips the multiplies. The reciprocal overlaps the four multiplies
// after the denominator, and the first multiply by it waits for the reciprocal to finish.
// Reset is synchronous and active low; it clears the velocity and sets smoothing time to 1.0.
// The input side is ready only between items, and a finished result waits in the output
// register while the next item is being worked on.
`default_nettype none

module smooth_damp_tracker import sdt_pkg::*; #(
    parameter int DATA_WIDTH = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    input  logic [159:0] i_s_tdata,   // cur_x, cur_y, target_x, target_y, step_time, zero pad
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    output logic [63:0]  o_m_tdata,   // out_x, out_y
    output logic [0:0]   o_m_tuser,   // overshoot
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [30:0]  i_cfg_data
);

    localparam int POS_W    = 32;
    localparam int TIME_W   = 31;
    localparam int DIFF_W   = POS_W + 1;
    localparam int X_W      = 27;
    localparam int X2_W     = 37;
    localparam int X3_W     = 47;
    localparam int T1_W     = 36;
    localparam int T2_W     = 44;
    localparam int OUT_BITS = (DATA_WIDTH < POS_W) ? DATA_WIDTH : POS_W;

    localparam logic [B_W-1:0]    K_048    = B_W'(31457);
    localparam logic [B_W-1:0]    K_0235   = B_W'(15401);
    localparam logic [TIME_W-1:0] ST_RESET = TIME_W'(65536);
    localparam logic [DEN_W-1:0]  DEN_BASE = DEN_W'(65536);
    localparam logic [X_W-1:0]    X_CAP    = X_W'(1024) << 16;
    localparam t_wide WIDE_LIM  = 64'sh2000_0000_0000_0000;
    localparam t_wide VEL_HI    = t_wide'((65'd1 << (DATA_WIDTH - 1)) - 65'd1);
    localparam t_wide VEL_LO    = -VEL_HI - t_wide'(1);
    localparam t_wide OUT_HI    = t_wide'((65'd1 << (OUT_BITS - 1)) - 65'd1);
    localparam t_wide OUT_LO    = -OUT_HI - t_wide'(1);

    typedef enum logic [1:0] {S_IDLE, S_ISSUE, S_WAIT, S_FIN} t_state;

    typedef enum logic [4:0] {
        ST_X, ST_X2, ST_X3, ST_T1, ST_T2,
        ST_MX, ST_TMX, ST_MY, ST_TMY,
        ST_PX, ST_PY, ST_D1, ST_D2,
        ST_VX1, ST_VX2, ST_VY1, ST_VY2
    } t_step;

    function automatic t_wide sat_wide(input t_wide v);
        if (v > WIDE_LIM) begin
            return WIDE_LIM;
        end
        if (v < -WIDE_LIM) begin
            return -WIDE_LIM;
        end
        return v;
    endfunction

    function automatic t_wide clamp_range(input t_wide v, input t_wide hi, input t_wide lo);
        if (v > hi) begin
            return hi;
        end
        if (v < lo) begin
            return lo;
        end
        return v;
    endfunction

    t_state                          r_state;
    t_step                           r_step;
    logic [TIME_W-1:0]               r_st;
    logic signed [DATA_WIDTH-1:0]    r_vel_x;
    logic signed [DATA_WIDTH-1:0]    r_vel_y;
    logic signed [POS_W-1:0]         r_tx;
    logic signed [POS_W-1:0]         r_ty;
    logic [TIME_W-1:0]               r_dt;
    logic signed [DIFF_W-1:0]        r_dx;
    logic signed [DIFF_W-1:0]        r_dy;
    logic [X_W-1:0]                  r_x;
    logic [X2_W-1:0]                 r_x2;
    logic [X3_W-1:0]                 r_x3;
    logic [T1_W-1:0]                 r_t1;
    t_wide                           r_m;
    t_wide                           r_tmx;
    t_wide                           r_tmy;
    t_wide                           r_px;
    t_wide                           r_py;
    logic [PROD_W-1:0]               r_p1;
    logic                            r_n1;
    logic                            r_mneg;
    logic                            r_pass;
    logic                            r_ovs;
    logic                            r_ovalid;
    logic signed [POS_W-1:0]         r_out_x;
    logic signed [POS_W-1:0]         r_out_y;
    logic                            r_out_ovs;

    logic signed [POS_W-1:0]  s_cur_x;
    logic signed [POS_W-1:0]  s_cur_y;
    logic signed [POS_W-1:0]  s_tgt_x;
    logic signed [POS_W-1:0]  s_tgt_y;
    logic [TIME_W-1:0]        s_step_time;
    logic                     s_xfer;

    t_wide                    vel_x_w;
    t_wide                    vel_y_w;
    t_wide                    dx_w;
    t_wide                    dy_w;
    logic [B_W-1:0]           dx_mag;
    logic [B_W-1:0]           dy_mag;
    t_wide                    op_a;
    logic [B_W-1:0]           op_b;
    logic                     need_d;
    logic                     mul_start;
    logic                     mul_done;
    logic [PROD_W-1:0]        mul_prod;
    logic [PROD_W-1:0]        prod_sh;
    logic [WIDE_W-1:0]        res_mag;
    t_wide                    mul_res;
    logic                     div_start;
    logic                     div_done;
    logic [QUO_W-1:0]         div_quo;
    logic [DEN_W-1:0]         den;
    logic                     n2;
    logic                     dot_neg;
    logic                     step_last;
    logic                     out_load;
    t_wide                    fin_x;
    t_wide                    fin_y;

    assign s_cur_x     = i_s_tdata[31:0];
    assign s_cur_y     = i_s_tdata[63:32];
    assign s_tgt_x     = i_s_tdata[95:64];
    assign s_tgt_y     = i_s_tdata[127:96];
    assign s_step_time = i_s_tdata[158:128];
    assign s_xfer      = i_s_tvalid && (r_state == S_IDLE);

    assign vel_x_w = t_wide'(r_vel_x);
    assign vel_y_w = t_wide'(r_vel_y);
    assign dx_w    = t_wide'(r_dx);
    assign dy_w    = t_wide'(r_dy);
    assign dx_mag  = r_dx[DIFF_W-1] ? B_W'(-r_dx) : B_W'(r_dx);
    assign dy_mag  = r_dy[DIFF_W-1] ? B_W'(-r_dy) : B_W'(r_dy);

    always_comb begin
        op_a   = t_wide'(r_st);
        op_b   = B_W'(r_dt);
        need_d = 1'b0;
        unique case (r_step)
            ST_X: begin
                op_a = t_wide'(r_st);
                op_b = B_W'(r_dt);
            end
            ST_X2: begin
                op_a = t_wide'(r_x);
                op_b = B_W'(r_x);
            end
            ST_X3: begin
                op_a = t_wide'(r_x2);
                op_b = B_W'(r_x);
            end
            ST_T1: begin
                op_a = t_wide'(r_x2);
                op_b = K_048;
            end
            ST_T2: begin
                op_a = t_wide'(r_x3);
                op_b = K_0235;
            end
            ST_MX: begin
                op_a = dx_w;
                op_b = B_W'(r_st);
            end
            ST_TMX: begin
                op_a = sat_wide(vel_x_w - r_m);
                op_b = B_W'(r_dt);
            end
            ST_MY: begin
                op_a = dy_w;
                op_b = B_W'(r_st);
            end
            ST_TMY: begin
                op_a = sat_wide(vel_y_w - r_m);
                op_b = B_W'(r_dt);
            end
            ST_PX: begin
                op_a   = sat_wide(dx_w + r_tmx);
                op_b   = B_W'(div_quo);
                need_d = 1'b1;
            end
            ST_PY: begin
                op_a   = sat_wide(dy_w + r_tmy);
                op_b   = B_W'(div_quo);
                need_d = 1'b1;
            end
            ST_D1: begin
                op_a = r_px;
                op_b = dx_mag;
            end
            ST_D2: begin
                op_a = r_py;
                op_b = dy_mag;
            end
            ST_VX1: begin
                op_a = r_tmx;
                op_b = B_W'(r_st);
            end
            ST_VX2: begin
                op_a   = sat_wide(vel_x_w - r_m);
                op_b   = B_W'(div_quo);
                need_d = 1'b1;
            end
            ST_VY1: begin
                op_a = r_tmy;
                op_b = B_W'(r_st);
            end
            ST_VY2: begin
                op_a   = sat_wide(vel_y_w - r_m);
                op_b   = B_W'(div_quo);
                need_d = 1'b1;
            end
            default: begin
                op_a = t_wide'(r_st);
                op_b = B_W'(r_dt);
            end
        endcase
    end

    assign mul_start = (r_state == S_ISSUE) && (!need_d || div_done);

    sdt_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (op_a),
        .i_b     (op_b),
        .o_done  (mul_done),
        .o_prod  (mul_prod)
    );

    // Scale the product magnitude back, saturate, then restore the sign.
    always_comb begin
        unique case (r_step)
            ST_X, ST_MX, ST_MY, ST_VX1, ST_VY1: prod_sh = mul_prod >> 17;
            ST_PX, ST_PY, ST_VX2, ST_VY2:       prod_sh = mul_prod >> 32;
            default:                            prod_sh = mul_prod >> 16;
        endcase
        res_mag = (prod_sh > PROD_W'(WIDE_LIM)) ? WIDE_LIM : prod_sh[WIDE_W-1:0];
        mul_res = r_mneg ? -t_wide'(res_mag) : t_wide'(res_mag);
    end

    assign den = DEN_BASE + DEN_W'(r_x) + DEN_W'(r_t1) + DEN_W'(mul_res[T2_W-1:0]);
    assign div_start = (r_state == S_WAIT) && mul_done && (r_step == ST_T2);

    sdt_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_den   (den),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    // The dot product is negative when both terms are negative, or when the negative term is the larger.
    assign n2      = (mul_prod != '0) && (r_dy[DIFF_W-1] != r_py[WIDE_W-1]);
    assign dot_neg = (r_n1 && n2) || (r_n1 && !n2 && (r_p1 > mul_prod))
                   || (!r_n1 && n2 && (mul_prod > r_p1));

    assign step_last = (r_step == ST_VY2) || ((r_step == ST_D2) && dot_neg);
    assign out_load  = (r_state == S_FIN) && (!r_ovalid || i_m_tready);

    always_comb begin
        if (r_pass || r_ovs) begin
            fin_x = clamp_range(t_wide'(r_tx), OUT_HI, OUT_LO);
            fin_y = clamp_range(t_wide'(r_ty), OUT_HI, OUT_LO);
        end else begin
            fin_x = clamp_range(sat_wide(t_wide'(r_tx) + r_px), OUT_HI, OUT_LO);
            fin_y = clamp_range(sat_wide(t_wide'(r_ty) + r_py), OUT_HI, OUT_LO);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_step   <= ST_X;
            r_st     <= ST_RESET;
            r_vel_x  <= '0;
            r_vel_y  <= '0;
            r_pass   <= 1'b0;
            r_ovs    <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_st <= i_cfg_data;
            end
            if (r_ovalid && i_m_tready && !out_load) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (s_xfer) begin
                        r_tx   <= s_tgt_x;
                        r_ty   <= s_tgt_y;
                        r_dt   <= s_step_time;
                        r_dx   <= DIFF_W'(s_cur_x) - DIFF_W'(s_tgt_x);
                        r_dy   <= DIFF_W'(s_cur_y) - DIFF_W'(s_tgt_y);
                        r_pass <= (r_st == '0);
                        r_ovs  <= 1'b0;
                        r_step <= ST_X;
                        r_state <= (r_st == '0) ? S_FIN : S_ISSUE;
                    end
                end
                S_ISSUE: begin
                    if (mul_start) begin
                        r_mneg  <= op_a[WIDE_W-1];
                        r_state <= S_WAIT;
                    end
                end
                S_WAIT: begin
                    if (mul_done) begin
                        r_state <= step_last ? S_FIN : S_ISSUE;
                        unique case (r_step)
                            ST_X: begin
                                r_x <= (mul_res > t_wide'(X_CAP)) ? X_CAP : mul_res[X_W-1:0];
                                r_step <= ST_X2;
                            end
                            ST_X2: begin
                                r_x2   <= mul_res[X2_W-1:0];
                                r_step <= ST_X3;
                            end
                            ST_X3: begin
                                r_x3   <= mul_res[X3_W-1:0];
                                r_step <= ST_T1;
                            end
                            ST_T1: begin
                                r_t1   <= mul_res[T1_W-1:0];
                                r_step <= ST_T2;
                            end
                            ST_T2: begin
                                r_step <= ST_MX;
                            end
                            ST_MX: begin
                                r_m    <= mul_res;
                                r_step <= ST_TMX;
                            end
                            ST_TMX: begin
                                r_tmx  <= mul_res;
                                r_step <= ST_MY;
                            end
                            ST_MY: begin
                                r_m    <= mul_res;
                                r_step <= ST_TMY;
                            end
                            ST_TMY: begin
                                r_tmy  <= mul_res;
                                r_step <= ST_PX;
                            end
                            ST_PX: begin
                                r_px   <= mul_res;
                                r_step <= ST_PY;
                            end
                            ST_PY: begin
                                r_py   <= mul_res;
                                r_step <= ST_D1;
                            end
                            ST_D1: begin
                                r_p1   <= mul_prod;
                                r_n1   <= (mul_prod != '0) && (r_dx[DIFF_W-1] != r_px[WIDE_W-1]);
                                r_step <= ST_D2;
                            end
                            ST_D2: begin
                                if (dot_neg) begin
                                    r_vel_x <= '0;
                                    r_vel_y <= '0;
                                    r_ovs   <= 1'b1;
                                end else begin
                                    r_step <= ST_VX1;
                                end
                            end
                            ST_VX1: begin
                                r_m    <= mul_res;
                                r_step <= ST_VX2;
                            end
                            ST_VX2: begin
                                r_vel_x <= DATA_WIDTH'(clamp_range(mul_res, VEL_HI, VEL_LO));
                                r_step  <= ST_VY1;
                            end
                            ST_VY1: begin
                                r_m    <= mul_res;
                                r_step <= ST_VY2;
                            end
                            ST_VY2: begin
                                r_vel_y <= DATA_WIDTH'(clamp_range(mul_res, VEL_HI, VEL_LO));
                            end
                            default: begin
                                r_step <= ST_X;
                            end
                        endcase
                    end
                end
                S_FIN: begin
                    if (out_load) begin
                        r_out_x   <= fin_x[POS_W-1:0];
                        r_out_y   <= fin_y[POS_W-1:0];
                        r_out_ovs <= r_ovs;
                        r_ovalid  <= 1'b1;
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_s_tready  = (r_state == S_IDLE);
    assign o_m_tvalid  = r_ovalid;
    assign o_m_tdata   = {r_out_y, r_out_x};
    assign o_m_tuser   = r_out_ovs;
    assign o_cfg_ready = 1'b1;

endmodule

`default_nettype wire
